### rtl/lsl_pkg.sv
// ----------------------------------------------------------------------------
// lsl_pkg: shared types and constants of the LRU slot list
// Pool geometry, command and status codes, sequencer states and the
// request/response bundles between the sequencer and the link store.
// ----------------------------------------------------------------------------
package lsl_pkg;

  localparam int POOL_SLOTS   = 256;
  localparam int SLOT_W       = 8;
  localparam int LINK_W       = 9;
  localparam int PAYLOAD_BITS = 32;
  localparam int CFG_W        = 9;

  // Link value that points nowhere.
  localparam logic [LINK_W-1:0] NONE_MARK = LINK_W'(POOL_SLOTS);

  localparam logic [2:0] CMD_ALLOC   = 3'd0;
  localparam logic [2:0] CMD_RELEASE = 3'd1;
  localparam logic [2:0] CMD_REMOVE  = 3'd2;
  localparam logic [2:0] CMD_TOUCH   = 3'd3;
  localparam logic [2:0] CMD_SETPAY  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_BADLINK = 2'd3;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DISPATCH,
    S_A_READ,
    S_R_READ,
    S_T_READ,
    S_T_LINK,
    S_T_TOP
  } seq_state_t;

  typedef struct packed {
    logic [SLOT_W-1:0]       rd_addr;
    logic                    older_we;
    logic [SLOT_W-1:0]       older_addr;
    logic [LINK_W-1:0]       older_wdata;
    logic                    newer_we;
    logic [SLOT_W-1:0]       newer_addr;
    logic [LINK_W-1:0]       newer_wdata;
    logic                    pay_we;
    logic [SLOT_W-1:0]       pay_addr;
    logic [PAYLOAD_BITS-1:0] pay_wdata;
  } mem_req_t;

  typedef struct packed {
    logic [LINK_W-1:0]       older;
    logic [LINK_W-1:0]       newer;
    logic [PAYLOAD_BITS-1:0] payload;
  } mem_rsp_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [SLOT_W-1:0]       slot;
    logic [PAYLOAD_BITS-1:0] payload;
  } result_t;

endpackage

### rtl/lsl_store.sv
// ----------------------------------------------------------------------------
// lsl_store: link and payload memories
// Three single-write-port arrays sharing one read address, with registered read data.
// ----------------------------------------------------------------------------
module lsl_store
  import lsl_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output mem_rsp_t rsp
);

  logic [LINK_W-1:0]       older_mem [POOL_SLOTS];
  logic [LINK_W-1:0]       newer_mem [POOL_SLOTS];
  logic [PAYLOAD_BITS-1:0] pay_mem   [POOL_SLOTS];

  always_ff @(posedge clk) begin
    if (req.older_we) begin
      older_mem[req.older_addr] <= req.older_wdata;
    end
    if (req.newer_we) begin
      newer_mem[req.newer_addr] <= req.newer_wdata;
    end
    if (req.pay_we) begin
      pay_mem[req.pay_addr] <= req.pay_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rsp.older   <= older_mem[req.rd_addr];
    rsp.newer   <= newer_mem[req.rd_addr];
    rsp.payload <= pay_mem[req.rd_addr];
  end

endmodule

### rtl/lsl_seq.sv
// ----------------------------------------------------------------------------
// lsl_seq: command sequencer
// Holds the list heads and steps each command through the link store.
// ----------------------------------------------------------------------------
module lsl_seq
  import lsl_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_fire,
  input  logic [CFG_W-1:0]        cfg_value,
  input  logic                    cmd_fire,
  input  logic [2:0]              cmd_in,
  input  logic [SLOT_W-1:0]       slot_in,
  input  logic [PAYLOAD_BITS-1:0] pay_in,
  output logic                    idle,
  input  logic                    out_free,
  output logic                    res_valid,
  output result_t                 res,
  output mem_req_t                req,
  input  mem_rsp_t                rsp
);

  seq_state_t state, state_next;
  logic       resp_pend, resp_pend_next;

  logic [2:0]              cmd;
  logic [SLOT_W-1:0]       slot;
  logic [PAYLOAD_BITS-1:0] pv;
  logic [CFG_W-1:0]        slots_cfg;
  logic [CFG_W-1:0]        cfg_clamped;
  logic [SLOT_W-1:0]       init_cnt;
  logic [LINK_W-1:0]       init_succ;

  logic [LINK_W-1:0] free_head, free_head_next;
  logic [LINK_W-1:0] oldest, oldest_next;
  logic [LINK_W-1:0] newest, newest_next;
  result_t           res_next;

  logic slot_ok;
  logic t_o_none, t_n_none, t_is_oldest;
  logic [LINK_W-1:0] slot_link;

  assign slot_link   = {1'b0, slot};
  assign slot_ok     = slot_link < slots_cfg;
  assign t_o_none    = rsp.older == NONE_MARK;
  assign t_n_none    = rsp.newer == NONE_MARK;
  assign t_is_oldest = oldest == slot_link;
  assign init_succ   = {1'b0, init_cnt} + LINK_W'(1);

  always_comb begin
    cfg_clamped = cfg_value;
    if (cfg_value == '0) begin
      cfg_clamped = CFG_W'(1);
    end else if (cfg_value > CFG_W'(POOL_SLOTS)) begin
      cfg_clamped = CFG_W'(POOL_SLOTS);
    end
  end

  assign idle      = (state == S_IDLE) && !resp_pend;
  assign res_valid = resp_pend;

  // Next state
  always_comb begin
    state_next     = state;
    resp_pend_next = resp_pend;
    if (resp_pend && out_free) begin
      resp_pend_next = 1'b0;
    end
    unique case (state)
      S_INIT: begin
        if (init_cnt == SLOT_W'(POOL_SLOTS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_fire) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        state_next     = S_IDLE;
        resp_pend_next = 1'b1;
        case (cmd)
          CMD_ALLOC: begin
            if (free_head != NONE_MARK) begin
              state_next     = S_A_READ;
              resp_pend_next = 1'b0;
            end
          end
          CMD_REMOVE: begin
            if (oldest != NONE_MARK) begin
              state_next     = S_R_READ;
              resp_pend_next = 1'b0;
            end
          end
          CMD_TOUCH: begin
            if (slot_ok && newest != slot_link) begin
              state_next     = S_T_READ;
              resp_pend_next = 1'b0;
            end
          end
          default: ;
        endcase
      end
      S_A_READ, S_R_READ: begin
        state_next     = S_IDLE;
        resp_pend_next = 1'b1;
      end
      S_T_READ: begin
        state_next     = S_IDLE;
        resp_pend_next = 1'b1;
        if (!t_n_none && (!t_o_none || t_is_oldest)) begin
          state_next     = S_T_LINK;
          resp_pend_next = 1'b0;
        end
      end
      S_T_LINK: begin
        if (newest != NONE_MARK) begin
          state_next = S_T_TOP;
        end else begin
          state_next     = S_IDLE;
          resp_pend_next = 1'b1;
        end
      end
      S_T_TOP: begin
        state_next     = S_IDLE;
        resp_pend_next = 1'b1;
      end
      default: state_next = S_INIT;
    endcase
    if (cfg_fire) begin
      state_next     = S_INIT;
      resp_pend_next = 1'b0;
    end
  end

  // Memory requests, head updates and result
  always_comb begin
    free_head_next = free_head;
    oldest_next    = oldest;
    newest_next    = newest;
    res_next       = res;
    req            = '0;

    case (cmd)
      CMD_ALLOC:  req.rd_addr = free_head[SLOT_W-1:0];
      CMD_REMOVE: req.rd_addr = oldest[SLOT_W-1:0];
      default:    req.rd_addr = slot;
    endcase

    unique case (state)
      S_INIT: begin
        req.older_we    = 1'b1;
        req.older_addr  = init_cnt;
        req.older_wdata = NONE_MARK;
        req.newer_we    = 1'b1;
        req.newer_addr  = init_cnt;
        req.newer_wdata = (init_succ < slots_cfg) ? init_succ : NONE_MARK;
        req.pay_we      = 1'b1;
        req.pay_addr    = init_cnt;
        req.pay_wdata   = '0;
      end
      S_IDLE: ;
      S_DISPATCH: begin
        res_next = '{status: ST_OK, slot: '0, payload: '0};
        case (cmd)
          CMD_ALLOC: begin
            if (free_head == NONE_MARK) res_next.status = ST_NO_FREE;
          end
          CMD_RELEASE: begin
            if (!slot_ok) begin
              res_next.status = ST_BADLINK;
            end else begin
              req.newer_we    = 1'b1;
              req.newer_addr  = slot;
              req.newer_wdata = free_head;
              free_head_next  = slot_link;
            end
          end
          CMD_REMOVE: begin
            if (oldest == NONE_MARK) res_next.status = ST_EMPTY;
          end
          CMD_TOUCH: begin
            if (!slot_ok) res_next.status = ST_BADLINK;
          end
          CMD_SETPAY: begin
            if (!slot_ok) begin
              res_next.status = ST_BADLINK;
            end else begin
              req.pay_we    = 1'b1;
              req.pay_addr  = slot;
              req.pay_wdata = pv;
            end
          end
          default: ;
        endcase
      end
      S_A_READ: begin
        // Pop the free head and clear the slot.
        res_next.slot   = free_head[SLOT_W-1:0];
        free_head_next  = rsp.newer;
        req.older_we    = 1'b1;
        req.older_addr  = free_head[SLOT_W-1:0];
        req.older_wdata = NONE_MARK;
        req.newer_we    = 1'b1;
        req.newer_addr  = free_head[SLOT_W-1:0];
        req.newer_wdata = NONE_MARK;
        req.pay_we      = 1'b1;
        req.pay_addr    = free_head[SLOT_W-1:0];
        req.pay_wdata   = '0;
      end
      S_R_READ: begin
        // Unlink the oldest slot and push it onto the free chain.
        res_next.slot    = oldest[SLOT_W-1:0];
        res_next.payload = rsp.payload;
        oldest_next      = rsp.newer;
        if (!t_n_none) begin
          req.older_we    = 1'b1;
          req.older_addr  = rsp.newer[SLOT_W-1:0];
          req.older_wdata = NONE_MARK;
        end else begin
          newest_next = NONE_MARK;
        end
        req.newer_we    = 1'b1;
        req.newer_addr  = oldest[SLOT_W-1:0];
        req.newer_wdata = free_head;
        free_head_next  = oldest;
      end
      S_T_READ: begin
        if (t_o_none && t_n_none) begin
          // Detached slot: append as newest.
          newest_next = slot_link;
          if (newest != NONE_MARK) begin
            req.newer_we    = 1'b1;
            req.newer_addr  = newest[SLOT_W-1:0];
            req.newer_wdata = slot_link;
            req.older_we    = 1'b1;
            req.older_addr  = slot;
            req.older_wdata = newest;
          end
          if (oldest == NONE_MARK) oldest_next = slot_link;
        end else if (!t_o_none && !t_n_none) begin
          req.newer_we    = 1'b1;
          req.newer_addr  = rsp.older[SLOT_W-1:0];
          req.newer_wdata = rsp.newer;
          req.older_we    = 1'b1;
          req.older_addr  = rsp.newer[SLOT_W-1:0];
          req.older_wdata = rsp.older;
        end else if (t_o_none && t_is_oldest) begin
          req.older_we    = 1'b1;
          req.older_addr  = rsp.newer[SLOT_W-1:0];
          req.older_wdata = NONE_MARK;
          oldest_next     = rsp.newer;
        end else begin
          res_next.status = ST_BADLINK;
        end
      end
      S_T_LINK: begin
        req.newer_we    = 1'b1;
        req.newer_addr  = slot;
        req.newer_wdata = NONE_MARK;
        if (newest != NONE_MARK) begin
          req.older_we    = 1'b1;
          req.older_addr  = slot;
          req.older_wdata = newest;
        end else begin
          newest_next = slot_link;
        end
      end
      S_T_TOP: begin
        req.newer_we    = 1'b1;
        req.newer_addr  = newest[SLOT_W-1:0];
        req.newer_wdata = slot_link;
        newest_next     = slot_link;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      resp_pend <= 1'b0;
      init_cnt  <= '0;
      slots_cfg <= CFG_W'(POOL_SLOTS);
      free_head <= '0;
      oldest    <= NONE_MARK;
      newest    <= NONE_MARK;
    end else begin
      state     <= state_next;
      resp_pend <= resp_pend_next;
      free_head <= free_head_next;
      oldest    <= oldest_next;
      newest    <= newest_next;
      if (state == S_INIT) begin
        init_cnt <= init_cnt + SLOT_W'(1);
      end
      if (cfg_fire) begin
        slots_cfg <= cfg_clamped;
        init_cnt  <= '0;
        free_head <= '0;
        oldest    <= NONE_MARK;
        newest    <= NONE_MARK;
      end
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if (cmd_fire) begin
      cmd  <= cmd_in;
      slot <= slot_in;
      pv   <= pay_in;
    end
  end

endmodule

### rtl/lru_slot_list_top.sv
// ----------------------------------------------------------------------------
// lru_slot_list_top: LRU slot list with free chain
// Slot pool kept as a free chain and a recency list, one command per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive as beats on the s_* stream: s_tuser holds the command
//   code, s_tdata the slot index and payload handle. Each command yields
//   exactly one result beat on the m_* stream: m_tuser holds the status,
//   m_tdata the result slot and result payload.
//   A beat on the cfg channel sets the slot count (0 reads as 1, values
//   above the pool size read as the pool size) and re-runs initialization.
// Timing:
//   One command at a time. Commands settled from the list heads finish
//   in the dispatch step; allocate and remove_oldest add a read step, and
//   touch a read step and, where needed, link and top steps, as set by the
//   one write port of each link memory and its registered read.
//   The next command is accepted the cycle after the result is registered.
// Reset and init:
//   After rst, and after every cfg beat, an init pass over every pool slot
//   writes the free chain into the link memories, one slot per cycle;
//   s_tready stays low during that pass. cfg_ready is always high.
// Stall:
//   The output register holds a result while m_tready is low; one more
//   result waits inside the sequencer, which then takes no new command.
// ----------------------------------------------------------------------------
module lru_slot_list_top
  import lsl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // configuration: slots_in_use
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  // command stream
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [39:0]      s_tdata,   // [7:0] slot_index, [39:8] payload_value
  input  logic [2:0]       s_tuser,   // [2:0] command
  // result stream
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [39:0]      m_tdata,   // [7:0] result_slot, [39:8] result_payload
  output logic [1:0]       m_tuser    // [1:0] status
);

  mem_req_t req;
  mem_rsp_t rsp;
  result_t  res;
  logic     res_valid;
  logic     idle;
  logic     out_free;
  logic     cfg_fire;
  logic     cmd_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign s_tready  = idle;
  assign cmd_fire  = s_tvalid && s_tready;
  // The output register frees up when empty or when its beat is taken.
  assign out_free  = !m_tvalid || m_tready;

  lsl_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_fire  (cfg_fire),
    .cfg_value (cfg_data),
    .cmd_fire  (cmd_fire),
    .cmd_in    (s_tuser),
    .slot_in   (s_tdata[SLOT_W-1:0]),
    .pay_in    (s_tdata[SLOT_W +: PAYLOAD_BITS]),
    .idle      (idle),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .req       (req),
    .rsp       (rsp)
  );

  lsl_store u_store (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

  // Output register: load a waiting result, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      m_tuser <= res.status;
      m_tdata <= {res.payload, res.slot};
    end
  end

endmodule

### rtl/lsl_check.sv
// ----------------------------------------------------------------------------
// lsl_check: port-level checks for the LRU slot list
// Watches the top-level ports and flags sequencing slips.
// ----------------------------------------------------------------------------
module lsl_check
  import lsl_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             cfg_valid,
  input logic             cfg_ready,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [39:0]      m_tdata,
  input logic [1:0]       m_tuser
);

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // Reset starts the init pass, so no command is taken right after it.
  a_reset_busy: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("command taken during init after reset");

  // A config beat restarts init.
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !s_tready)
    else $error("command taken during init after config");

  // One command at a time.
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second command taken back to back");

  // Failed commands report zero slot and payload.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
    else $error("nonzero result data on failed command");

endmodule

bind lru_slot_list_top lsl_check u_check (.*);

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for lru_slot_list_top
// Drives command beats into the slot list, keeps its own model of the free
// chain and the recency list, and checks every result beat in order. Runs
// directed corner cases, slot-count limits, output back-pressure, a full
// drain pause and long random phases over several slot counts.
// ----------------------------------------------------------------------------
module tb;
  import lsl_pkg::*;

  // Command codes the block treats as no-ops.
  localparam logic [2:0] CMD_SPARE_5 = 3'd5;
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  // Cycles with no beat on any channel before the run is declared hung.
  // Worst legal quiet stretch is the init pass over the whole pool or the
  // long output hold below, so this leaves a wide margin.
  localparam int STALL_LIMIT     = 2000;
  localparam int RX_HOLD_CYCLES  = 300;
  localparam int CFG_QUIET       = 4;
  localparam int TAIL_CYCLES     = 10;
  localparam int PHASE_ITEMS     = 180;

  typedef enum int { RX_FREE, RX_RANDOM, RX_BURSTY } rx_mode_t;
  // Intended use of each slot, as seen by the stimulus generator.
  typedef enum int { ROLE_FREE, ROLE_HELD, ROLE_LINKED } role_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [39:0]             s_tdata = '0;   // [7:0] slot_index, [39:8] payload_value
  logic [2:0]              s_tuser = '0;   // [2:0] command
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [39:0]             m_tdata;        // [7:0] result_slot, [39:8] result_payload
  logic [1:0]              m_tuser;        // [1:0] status

  always #5 clk = ~clk;

  lru_slot_list_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // --------------------------------------------------------------------------
  // Slot list model: links, payloads, list ends and free chain head
  // --------------------------------------------------------------------------
  logic [LINK_W-1:0]       older_of  [POOL_SLOTS];
  logic [LINK_W-1:0]       newer_of  [POOL_SLOTS];
  logic [PAYLOAD_BITS-1:0] handle_of [POOL_SLOTS];
  logic [LINK_W-1:0]       mru_slot;
  logic [LINK_W-1:0]       lru_slot;
  logic [LINK_W-1:0]       free_top;
  int                      slot_count;
  role_t                   slot_role [POOL_SLOTS];

  // Results still owed by the block, oldest first.
  result_t                 pending_results[$];
  int                      mismatches = 0;
  int                      idle_cycles = 0;

  // Sender and receiver pacing controls, set by the test tasks.
  bit                      tx_idle_en = 1'b0;
  int                      tx_burst_left = 0;
  rx_mode_t                rx_mode = RX_FREE;
  bit                      rx_hold_req = 1'b0;
  int                      rx_hold_left = 0;
  int                      rx_run_left = 0;
  bit                      rx_run_ready = 1'b1;

  // Chain every configured slot into the free list, empty the recency list.
  function automatic void pool_init();
    for (int i = 0; i < POOL_SLOTS; i++) begin
      older_of[i]  = NONE_MARK;
      newer_of[i]  = (i + 1 < slot_count) ? LINK_W'(i + 1) : NONE_MARK;
      handle_of[i] = '0;
      slot_role[i] = ROLE_FREE;
    end
    mru_slot = NONE_MARK;
    lru_slot = NONE_MARK;
    free_top = '0;
  endfunction

  // Move a slot to the newest end of the recency list.
  function automatic logic [1:0] promote_slot(input logic [LINK_W-1:0] s);
    logic [LINK_W-1:0] dn, up, top;
    top = mru_slot;
    if (top == s) return ST_OK;
    dn = older_of[s];
    up = newer_of[s];
    // Unlinked slot: append it as the newest, and as the oldest too if alone.
    if (dn == NONE_MARK && up == NONE_MARK) begin
      mru_slot = s;
      if (top != NONE_MARK) begin
        newer_of[top] = s;
        older_of[s]   = top;
      end
      if (lru_slot == NONE_MARK) lru_slot = s;
      return ST_OK;
    end
    if (dn != NONE_MARK && up != NONE_MARK) begin
      newer_of[dn] = up;
      older_of[up] = dn;
    end else if (dn == NONE_MARK) begin
      // No older link is only legal for the oldest slot.
      if (lru_slot != s) return ST_BADLINK;
      older_of[up] = NONE_MARK;
      lru_slot     = up;
    end else begin
      // An older link but no newer one, yet not the newest: broken list.
      return ST_BADLINK;
    end
    mru_slot    = s;
    newer_of[s] = NONE_MARK;
    if (top != NONE_MARK) begin
      newer_of[top] = s;
      older_of[s]   = top;
    end
    return ST_OK;
  endfunction

  // Apply one command to the model and return the result it must produce.
  function automatic result_t predict_cmd(input logic [2:0] cmd, input logic [SLOT_W-1:0] s,
                                          input logic [PAYLOAD_BITS-1:0] pv);
    result_t           r;
    logic              in_pool;
    logic [LINK_W-1:0] idx;
    r       = '0;
    idx     = {1'b0, s};
    in_pool = int'(s) < slot_count;
    case (cmd)
      CMD_ALLOC: begin
        if (free_top == NONE_MARK) begin
          r.status = ST_NO_FREE;
        end else begin
          idx            = free_top;
          r.slot         = idx[SLOT_W-1:0];
          free_top       = newer_of[idx];
          older_of[idx]  = NONE_MARK;
          newer_of[idx]  = NONE_MARK;
          handle_of[idx] = '0;
        end
      end
      CMD_RELEASE: begin
        // Pushes onto the free chain without unlinking from the list.
        if (!in_pool) begin
          r.status = ST_BADLINK;
        end else begin
          newer_of[idx] = free_top;
          free_top      = idx;
        end
      end
      CMD_REMOVE: begin
        if (lru_slot == NONE_MARK) begin
          r.status = ST_EMPTY;
        end else begin
          idx       = lru_slot;
          r.slot    = idx[SLOT_W-1:0];
          r.payload = handle_of[idx];
          lru_slot  = newer_of[idx];
          if (lru_slot != NONE_MARK) older_of[lru_slot] = NONE_MARK;
          else mru_slot = NONE_MARK;
          newer_of[idx] = free_top;
          free_top      = idx;
        end
      end
      CMD_TOUCH: r.status = in_pool ? promote_slot(idx) : ST_BADLINK;
      CMD_SETPAY: begin
        if (!in_pool) r.status = ST_BADLINK;
        else handle_of[idx] = pv;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Random slot of the given role within the configured pool, or -1.
  function automatic int pick_role(input role_t want);
    int cands[$];
    for (int i = 0; i < slot_count; i++)
      if (slot_role[i] == want) cands.push_back(i);
    if (cands.size() == 0) return -1;
    return cands[$urandom_range(cands.size() - 1)];
  endfunction

  // --------------------------------------------------------------------------
  // Command side
  // --------------------------------------------------------------------------
  // Offer one command beat, hold it until accepted, then log its result.
  // In idle mode the sender runs in bursts and drops tvalid between them.
  task automatic send_cmd(input logic [2:0] cmd, input int s, input logic [31:0] pv);
    int      gap;
    result_t r;
    if (tx_idle_en) begin
      if (tx_burst_left == 0) begin
        tx_burst_left = $urandom_range(1, 16);
        gap = $urandom_range(0, 10);
        if (gap > 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      tx_burst_left--;
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {pv, SLOT_W'(s)};
    do @(posedge clk); while (!s_tready);
    r = predict_cmd(cmd, SLOT_W'(s), pv);
    pending_results.push_back(r);
    // Track what the stimulus meant each slot to be.
    case (cmd)
      CMD_ALLOC:   if (r.status == ST_OK) slot_role[r.slot] = ROLE_HELD;
      CMD_TOUCH:   if (r.status == ST_OK) slot_role[s] = ROLE_LINKED;
      CMD_REMOVE:  if (r.status == ST_OK) slot_role[r.slot] = ROLE_FREE;
      CMD_RELEASE: if (r.status == ST_OK) slot_role[s] = ROLE_FREE;
      default: ;
    endcase
  endtask

  // Drop tvalid and wait until every result beat has come back.
  task automatic settle_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Write the slot count on an idle block; the model re-runs its init.
  task automatic write_slot_count(input int v);
    logic [CFG_W-1:0] raw;
    int               eff;
    settle_results();
    repeat (CFG_QUIET) @(posedge clk);
    raw = CFG_W'(v);
    cfg_valid <= 1'b1;
    cfg_data  <= raw;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    eff = int'(raw);
    if (eff < 1) eff = 1;
    if (eff > POOL_SLOTS) eff = POOL_SLOTS;
    slot_count = eff;
    pool_init();
  endtask

  // Mostly well-formed use of the pool: allocate, link, promote, tag, evict
  // and give back; a small share is noise (any code, any index, release of
  // a slot still on the list).
  task automatic issue_random_cmd();
    int         pick, s, held, linked;
    logic [2:0] cmd;
    pick   = $urandom_range(99);
    held   = pick_role(ROLE_HELD);
    linked = pick_role(ROLE_LINKED);
    cmd    = CMD_ALLOC;
    s      = $urandom_range(slot_count - 1);
    if (pick < 6) begin
      cmd = 3'($urandom_range(7));
      s   = $urandom_range(255);
      if (pick == 0 && linked >= 0) begin
        cmd = CMD_RELEASE;
        s   = linked;
      end
    end else if (pick < 30) begin
      cmd = CMD_ALLOC;
    end else if (pick < 45 && held >= 0) begin
      cmd = CMD_TOUCH;
      s   = held;
    end else if (pick < 62 && linked >= 0) begin
      cmd = CMD_TOUCH;
      s   = linked;
    end else if (pick < 77) begin
      cmd = CMD_REMOVE;
    end else if (pick < 85 && held >= 0) begin
      cmd = CMD_RELEASE;
      s   = held;
    end else begin
      cmd = CMD_SETPAY;
      if (linked >= 0) s = linked;
    end
    send_cmd(cmd, s, $urandom());
  endtask

  // --------------------------------------------------------------------------
  // Result side: stall pattern, long hold on request, in-order check
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_hold_req) begin
      rx_hold_req  = 1'b0;
      rx_hold_left = RX_HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_FREE:   m_tready <= 1'b1;
        RX_RANDOM: m_tready <= ($urandom_range(99) < 70);
        default: begin
          // Alternate ready and stalled runs of random length.
          if (rx_run_left == 0) begin
            rx_run_ready = !rx_run_ready;
            rx_run_left  = rx_run_ready ? $urandom_range(1, 12) : $urandom_range(1, 6);
          end
          rx_run_left--;
          m_tready <= rx_run_ready;
        end
      endcase
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat: status %0d slot %0d payload %h",
                 $time, m_tuser, m_tdata[7:0], m_tdata[39:8]);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, want.status, m_tuser);
          mismatches++;
        end
        if (m_tdata[7:0] !== want.slot) begin
          $display("%0t: result_slot mismatch: expected %0d actual %0d",
                   $time, want.slot, m_tdata[7:0]);
          mismatches++;
        end
        if (m_tdata[39:8] !== want.payload) begin
          $display("%0t: result_payload mismatch: expected %h actual %h",
                   $time, want.payload, m_tdata[39:8]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: count cycles with no beat on any channel.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // List ends and promotion paths on the full pool straight after reset.
  task automatic test_recency_directed();
    tx_idle_en = 1'b1;
    rx_mode    = RX_BURSTY;
    send_cmd(CMD_REMOVE, 0, '0);              // empty list
    send_cmd(CMD_ALLOC, 0, '0);
    send_cmd(CMD_ALLOC, 0, '0);
    send_cmd(CMD_ALLOC, 0, '0);
    send_cmd(CMD_TOUCH, 0, '0);               // first slot onto an empty list
    send_cmd(CMD_TOUCH, 1, '0);
    send_cmd(CMD_TOUCH, 2, '0);
    send_cmd(CMD_TOUCH, 2, '0);               // newest stays put
    send_cmd(CMD_TOUCH, 0, '0);               // oldest to newest
    send_cmd(CMD_TOUCH, 2, '0);               // middle to newest
    send_cmd(CMD_SETPAY, 1, 32'hFFFF_FFFF);
    send_cmd(CMD_SETPAY, 255, 32'h5A5A_5A5A); // top slot of the pool
    send_cmd(CMD_REMOVE, 0, '0);              // evict with payload
    send_cmd(CMD_TOUCH, 7, '0);               // free slot, no older link, not oldest
    send_cmd(CMD_SPARE_5, 0, '0);
    send_cmd(CMD_SPARE_6, 255, 32'hFFFF_FFFF);
    send_cmd(CMD_SPARE_7, 0, '0);
  endtask

  // Tiny pools, index range checks and out-of-range register values.
  task automatic test_slot_count_limits();
    write_slot_count(2);
    send_cmd(CMD_ALLOC, 0, '0);
    send_cmd(CMD_ALLOC, 0, '0);
    send_cmd(CMD_ALLOC, 0, '0);               // free chain empty
    send_cmd(CMD_SETPAY, 2, 32'h1234_5678);   // outside configured pool
    send_cmd(CMD_RELEASE, 255, '0);
    send_cmd(CMD_TOUCH, 1, '0);
    send_cmd(CMD_REMOVE, 0, '0);
    send_cmd(CMD_RELEASE, 0, '0);
    write_slot_count(0);                      // reads as one slot
    send_cmd(CMD_ALLOC, 0, '0);
    send_cmd(CMD_ALLOC, 0, '0);
    send_cmd(CMD_TOUCH, 0, '0);
    send_cmd(CMD_REMOVE, 0, '0);
    send_cmd(CMD_REMOVE, 0, '0);
    write_slot_count(511);                    // clamps to the pool size
    send_cmd(CMD_ALLOC, 0, '0);
    send_cmd(CMD_ALLOC, 0, '0);
  endtask

  // Hold the result side for a long stretch while commands keep coming,
  // so the block fills up and stalls its input.
  task automatic test_output_backpressure();
    tx_idle_en  = 1'b0;
    rx_mode     = RX_FREE;
    rx_hold_req = 1'b1;
    repeat (24) issue_random_cmd();
    settle_results();
  endtask

  // Pause the sender until the block has answered everything, then resume.
  task automatic test_drain_pause();
    tx_idle_en = 1'b1;
    rx_mode    = RX_RANDOM;
    repeat (30) issue_random_cmd();
    settle_results();
    repeat (30) issue_random_cmd();
  endtask

  // Random phases over a spread of slot counts and pacing styles.
  task automatic test_random_traffic();
    int counts[10] = '{256, 1, 3, 8, 17, 64, 257, 130, 5, 255};
    for (int p = 0; p < 10; p++) begin
      write_slot_count(counts[p]);
      rx_mode    = rx_mode_t'(p % 3);
      tx_idle_en = (p % 4) != 0;
      repeat (PHASE_ITEMS) issue_random_cmd();
    end
  endtask

  initial begin
    slot_count = POOL_SLOTS;
    pool_init();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_recency_directed();
    test_slot_count_limits();
    test_output_backpressure();
    test_drain_pause();
    test_random_traffic();
    settle_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

### files.f
rtl/lsl_pkg.sv
rtl/lsl_store.sv
rtl/lsl_seq.sv
rtl/lru_slot_list_top.sv
rtl/lsl_check.sv
tb/sv/tb.sv
